// ===== rtl/core/crsc_pkg.sv =====
// ----------------------------------------------------------------------------
// crsc_pkg
// Shared types, codes and helpers of the Catmull-Rom span coefficient block.
// ----------------------------------------------------------------------------
package crsc_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned GAP_W   = 33;
    localparam int unsigned SQ_W    = 63;
    localparam int unsigned COEF_W  = 48;

    // result status codes
    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_FEW = 2'd1;
    localparam logic [1:0] STAT_OVF = 2'd2;

    // knot spacing modes, anything else is centripetal
    localparam logic [1:0] KNOT_UNIFORM = 2'd0;
    localparam logic [1:0] KNOT_CHORDAL = 2'd1;

    // configuration register indexes
    localparam logic [1:0] CFG_KNOT_MODE   = 2'd0;
    localparam logic [1:0] CFG_CLOSED_LOOP = 2'd1;
    localparam logic [1:0] CFG_AXIS_COUNT  = 2'd2;

    localparam logic [GAP_W-1:0] GAP_UNIT = 33'd65536;
    localparam int unsigned SPAN_LIMIT = 16;

    localparam logic signed [63:0] SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_LO = 64'shFFFF_8000_0000_0000;

    typedef struct packed {
        logic       ld;
        logic [1:0] ld_slot;
        logic       sq_en;
        logic [1:0] gap_sel;
        logic       term_start;
        logic       m1_zero;
        logic       m2_zero;
    } t_lane_ctl;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
    } t_coefs;

    function automatic logic signed [COEF_W-1:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI;
        end else if (v < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = v;
        end
        return r[COEF_W-1:0];
    endfunction

endpackage

// ===== rtl/core/crsc_ram.sv =====
// ----------------------------------------------------------------------------
// crsc_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module crsc_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/crsc_sqrt.sv =====
// ----------------------------------------------------------------------------
// crsc_sqrt
// Bit serial integer square root of a 64 bit value, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module crsc_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic        r_done;
    logic [63:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_bit <= 64'h4000_0000_0000_0000;
            end else if (r_bit != '0) begin
                r_bit <= r_bit >> 2;
                if (r_bit == 64'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
        end else if (r_bit != '0) begin
            if (r_x >= trial) begin
                r_x   <= r_x - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

// ===== rtl/core/crsc_muldiv.sv =====
// ----------------------------------------------------------------------------
// crsc_muldiv
// Serial floor(a*n/c): shift-add multiply, then restoring divide, capped at 2^56.
// ----------------------------------------------------------------------------
module crsc_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_a,
    input  logic [32:0] i_n,
    input  logic [33:0] i_c,
    output logic        o_done,
    output logic [56:0] o_q
);

    localparam int unsigned MUL_STEPS = 33;
    localparam int unsigned DIV_STEPS = 66;

    logic        r_busy;
    logic        r_mul;
    logic [6:0]  r_cnt;
    logic        r_done;
    logic [32:0] r_a;
    logic [32:0] r_n;
    logic [33:0] r_c;
    logic [65:0] r_prod;
    logic [33:0] r_rem;

    logic [34:0] rem_sh;
    logic        ge;
    logic [34:0] rem_nx;
    logic        over;

    assign rem_sh = {r_rem, r_prod[65]};
    assign ge     = rem_sh >= {1'b0, r_c};
    assign rem_nx = ge ? (rem_sh - {1'b0, r_c}) : rem_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_mul  <= 1'b1;
                r_cnt  <= 7'(MUL_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    if (r_mul) begin
                        r_mul <= 1'b0;
                        r_cnt <= 7'(DIV_STEPS - 1);
                    end else begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_cnt <= r_cnt - 7'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_n    <= i_n;
            r_c    <= i_c;
            r_prod <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            if (r_mul) begin
                r_prod <= {r_prod[64:0], 1'b0} + (r_n[32] ? {33'd0, r_a} : 66'd0);
                r_n    <= {r_n[31:0], 1'b0};
            end else begin
                r_rem  <= rem_nx[33:0];
                r_prod <= {r_prod[64:0], ge};
            end
        end
    end

    assign over   = (|r_prod[65:57]) || (r_prod[56] && (|r_prod[55:0]));
    assign o_q    = over ? {1'b1, 56'd0} : r_prod[56:0];
    assign o_done = r_done;

endmodule

// ===== rtl/core/crsc_lane.sv =====
// ----------------------------------------------------------------------------
// crsc_lane
// One axis lane: holds the four span points of its axis, squares a point
// difference for the knot gap and forms the four tangent terms and a,b,c,d.
// ----------------------------------------------------------------------------
module crsc_lane (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  crsc_pkg::t_lane_ctl        i_ctl,
    input  logic signed [31:0]         i_coord,
    input  logic [crsc_pkg::GAP_W-1:0] i_g01,
    input  logic [crsc_pkg::GAP_W-1:0] i_g12,
    input  logic [crsc_pkg::GAP_W-1:0] i_g23,
    output logic [crsc_pkg::SQ_W-1:0]  o_sq,
    output logic                       o_done,
    output crsc_pkg::t_coefs           o_coef
);

    logic signed [31:0] r_p [4];
    logic [crsc_pkg::SQ_W-1:0] r_sq;
    logic signed [57:0] r_t [4];
    logic signed [63:0] r_m1;
    logic signed [63:0] r_m2;
    logic [1:0] r_tk;
    logic       r_go;
    logic       r_fin;
    logic       r_done;

    logic signed [32:0] d10, d21, d32, d20, d31;
    logic signed [32:0] sd;
    logic [32:0]        sm;
    logic [65:0]        sq_full;
    logic signed [32:0] tv;
    logic [32:0]        tmag;
    logic [33:0]        tc;
    logic               md_done;
    logic [56:0]        md_q;
    logic signed [63:0] p1_w, p2_w;

    assign d10 = {r_p[1][31], r_p[1]} - {r_p[0][31], r_p[0]};
    assign d21 = {r_p[2][31], r_p[2]} - {r_p[1][31], r_p[1]};
    assign d32 = {r_p[3][31], r_p[3]} - {r_p[2][31], r_p[2]};
    assign d20 = {r_p[2][31], r_p[2]} - {r_p[0][31], r_p[0]};
    assign d31 = {r_p[3][31], r_p[3]} - {r_p[1][31], r_p[1]};

    always_comb begin
        case (i_ctl.gap_sel)
            2'd0:    sd = d10;
            2'd1:    sd = d21;
            default: sd = d32;
        endcase
    end

    assign sm      = sd[32] ? 33'(-sd) : 33'(sd);
    assign sq_full = sm * sm;

    // term order: (p2-p0, g01+g12), (p1-p0, g01), (p3-p1, g12+g23), (p3-p2, g23)
    always_comb begin
        unique case (r_tk)
            2'd0: begin
                tv = d20;
                tc = {1'b0, i_g01} + {1'b0, i_g12};
            end
            2'd1: begin
                tv = d10;
                tc = {1'b0, i_g01};
            end
            2'd2: begin
                tv = d31;
                tc = {1'b0, i_g12} + {1'b0, i_g23};
            end
            default: begin
                tv = d32;
                tc = {1'b0, i_g23};
            end
        endcase
    end

    assign tmag = tv[32] ? 33'(-tv) : 33'(tv);

    crsc_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (tmag),
        .i_n     (i_g12),
        .i_c     (tc),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tk   <= '0;
            r_go   <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_go   <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= r_fin;
            if (i_ctl.term_start) begin
                r_tk <= '0;
                r_go <= 1'b1;
            end else if (md_done) begin
                if (r_tk == 2'd3) begin
                    r_fin <= 1'b1;
                end else begin
                    r_tk <= r_tk + 2'd1;
                    r_go <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            r_p[i_ctl.ld_slot] <= i_coord;
        end
        if (i_ctl.sq_en) begin
            r_sq <= sq_full[64:2];
        end
        if (md_done) begin
            r_t[r_tk] <= tv[32] ? -$signed({1'b0, md_q}) : $signed({1'b0, md_q});
        end
        if (r_fin) begin
            r_m1 <= i_ctl.m1_zero ? 64'sd0
                  : 64'(d21) - 64'(r_t[0]) + 64'(r_t[1]);
            r_m2 <= i_ctl.m2_zero ? 64'sd0
                  : 64'(d21) - 64'(r_t[2]) + 64'(r_t[3]);
        end
    end

    assign p1_w = 64'(r_p[1]);
    assign p2_w = 64'(r_p[2]);

    assign o_coef.a = crsc_pkg::sat48(((p1_w - p2_w) <<< 1) + r_m1 + r_m2);
    assign o_coef.b = crsc_pkg::sat48(64'(d21) + 64'(d21) + 64'(d21)
                                      - (r_m1 <<< 1) - r_m2);
    assign o_coef.c = crsc_pkg::sat48(r_m1);
    assign o_coef.d = crsc_pkg::sat48(p1_w);
    assign o_sq     = r_sq;
    assign o_done   = r_done;

endmodule

// ===== rtl/core/catmull_rom_span_coeffs.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_span_coeffs
// Catmull-Rom span coefficient generator with uniform, chordal or centripetal
// knots, three axis lanes and a shared square root unit.
// ----------------------------------------------------------------------------
// Control points are taken one per cycle. The point that carries tlast ends
// the curve; the block then works span by span and takes no new point until
// the last result of the curve is in the output register. Per span it reads
// the four points, then for each of three knot gaps squares the lane
// differences and runs the shared square root, for centripetal knots once
// more on that root; uniform knots skip this and take a fixed unit gap.
// Then every axis lane forms its four tangent terms on its serial
// multiply-divide unit, and the block emits one result per used axis when
// the output is not stalled. The point store is a RAM of MAX_POINTS
// entries and needs no clearing.
module catmull_rom_span_coeffs #(
    parameter int unsigned MAX_POINTS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // coord_x [31:0], coord_y [63:32], coord_z [95:64]
    input  logic [95:0]  i_s_axis_tdata,
    input  logic         i_s_axis_tlast,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // span_index [3:0], axis [5:4], coef_a [53:6], coef_b [101:54],
    // coef_c [149:102], coef_d [197:150], zero [199:198]
    output logic [199:0] o_m_axis_tdata,
    // status [1:0]
    output logic [1:0]   o_m_axis_tuser,
    output logic         o_m_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [1:0]   i_cfg_data
);

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);
    localparam int unsigned IW = ((CW > 4) ? CW : 4) + 1;

    typedef enum logic [9:0] {
        S_LOAD  = 10'b00_0000_0001,
        S_STAT  = 10'b00_0000_0010,
        S_RD    = 10'b00_0000_0100,
        S_SQ    = 10'b00_0000_1000,
        S_SUM   = 10'b00_0001_0000,
        S_RT1   = 10'b00_0010_0000,
        S_RT2   = 10'b00_0100_0000,
        S_TERM  = 10'b00_1000_0000,
        S_TWAIT = 10'b01_0000_0000,
        S_EMIT  = 10'b10_0000_0000
    } t_state;

    t_state      r_state;
    logic [1:0]  r_knot;
    logic        r_closed;
    logic [1:0]  r_axcnt;
    logic [CW-1:0] r_count;
    logic        r_ovf;
    logic [CW-1:0] r_n;
    logic [4:0]  r_spans;
    logic [3:0]  r_span;
    logic [1:0]  r_ax;
    logic [2:0]  r_rk;
    logic        r_ld;
    logic [1:0]  r_ld_slot;
    logic [1:0]  r_gj;
    logic [crsc_pkg::GAP_W-1:0] r_gap [3];
    logic [1:0]  r_status;
    logic        r_out_valid;
    logic [199:0] r_out_data;
    logic [1:0]  r_out_user;
    logic        r_out_last;

    logic        in_acc;
    logic        full;
    logic        three;
    logic [CW-1:0] cnt_new;
    logic        few;
    logic [IW-1:0] spans_raw;
    logic [4:0]  spans;
    logic [IW-1:0] s_w, n_w, idx;
    logic [95:0] ram_rdata;
    logic        slot_free;
    logic        last_res;
    logic [1:0]  last_ax;

    crsc_pkg::t_lane_ctl lane_ctl;
    logic [crsc_pkg::SQ_W-1:0] lane_sq [3];
    logic [2:0]       lane_done;
    crsc_pkg::t_coefs lane_coef [3];
    crsc_pkg::t_coefs sel_coef;

    logic        sq_start;
    logic [63:0] sq_x;
    logic [63:0] sq_sum;
    logic        sq_done;
    logic [31:0] sq_root;

    assign o_s_axis_tready = (r_state == S_LOAD);
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign full      = (r_count == CW'(MAX_POINTS));
    assign cnt_new   = full ? r_count : r_count + CW'(1);
    assign three     = (r_axcnt != 2'd2);
    assign few       = r_closed ? (cnt_new < CW'(3)) : (cnt_new < CW'(4));
    assign spans_raw = r_closed ? IW'(cnt_new) : IW'(cnt_new) - IW'(3);
    assign spans     = (spans_raw > IW'(crsc_pkg::SPAN_LIMIT))
                     ? 5'(crsc_pkg::SPAN_LIMIT) : spans_raw[4:0];

    // closed curves wrap the neighbor indices around the point count
    assign s_w = IW'(r_span);
    assign n_w = IW'(r_n);
    always_comb begin
        unique case (r_rk[1:0])
            2'd0: idx = !r_closed ? s_w : ((s_w == '0) ? n_w - IW'(1) : s_w - IW'(1));
            2'd1: idx = !r_closed ? s_w + IW'(1) : s_w;
            2'd2: idx = !r_closed ? s_w + IW'(2)
                      : ((s_w + IW'(1) == n_w) ? '0 : s_w + IW'(1));
            default: idx = !r_closed ? s_w + IW'(3)
                         : ((s_w + IW'(2) >= n_w) ? s_w + IW'(2) - n_w : s_w + IW'(2));
        endcase
    end

    crsc_ram #(
        .WIDTH (96),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc && !full),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        lane_ctl.ld         = r_ld;
        lane_ctl.ld_slot    = r_ld_slot;
        lane_ctl.sq_en      = (r_state == S_SQ);
        lane_ctl.gap_sel    = r_gj;
        lane_ctl.term_start = (r_state == S_TERM);
        lane_ctl.m1_zero    = (r_gap[0] == '0) || (r_gap[1] == '0);
        lane_ctl.m2_zero    = (r_gap[1] == '0) || (r_gap[2] == '0);
    end

    for (genvar k = 0; k < 3; k++) begin : g_lane
        crsc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_coord (ram_rdata[32*k +: 32]),
            .i_g01   (r_gap[0]),
            .i_g12   (r_gap[1]),
            .i_g23   (r_gap[2]),
            .o_sq    (lane_sq[k]),
            .o_done  (lane_done[k]),
            .o_coef  (lane_coef[k])
        );
    end

    // merge: a quarter of the squared distance over the used axes, then the shared root
    assign sq_sum = {1'b0, lane_sq[0]} + {1'b0, lane_sq[1]}
                  + (three ? {1'b0, lane_sq[2]} : 64'd0);
    assign sq_start = (r_state == S_SUM)
                   || ((r_state == S_RT1) && sq_done && (r_knot != crsc_pkg::KNOT_CHORDAL));
    assign sq_x = (r_state == S_SUM) ? sq_sum : {15'd0, sq_root, 17'd0};

    crsc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (sq_x),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign slot_free = !r_out_valid || i_m_axis_tready;
    assign last_ax   = three ? 2'd2 : 2'd1;
    assign last_res  = ({1'b0, r_span} + 5'd1 == r_spans) && (r_ax == last_ax);

    always_comb begin
        unique case (r_ax)
            2'd0:    sel_coef = lane_coef[0];
            2'd1:    sel_coef = lane_coef[1];
            default: sel_coef = lane_coef[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_knot      <= 2'd2;
            r_closed    <= 1'b0;
            r_axcnt     <= 2'd3;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_ld        <= 1'b0;
            r_rk        <= '0;
            r_gj        <= '0;
            r_ax        <= '0;
            r_span      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    crsc_pkg::CFG_KNOT_MODE:   r_knot   <= i_cfg_data;
                    crsc_pkg::CFG_CLOSED_LOOP: r_closed <= i_cfg_data[0];
                    crsc_pkg::CFG_AXIS_COUNT:  r_axcnt  <= i_cfg_data;
                    default: ;
                endcase
            end
            // the result states refill the slot on the same edge
            if (r_out_valid && i_m_axis_tready && (r_state != S_STAT)
                    && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            // read data lands in the cycle after its address
            r_ld <= (r_state == S_RD) && !r_rk[2];

            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (i_s_axis_tlast) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_n     <= cnt_new;
                            r_spans <= spans;
                            r_span  <= '0;
                            r_rk    <= '0;
                            if (r_ovf || full) begin
                                r_status <= crsc_pkg::STAT_OVF;
                                r_state  <= S_STAT;
                            end else if (few) begin
                                r_status <= crsc_pkg::STAT_FEW;
                                r_state  <= S_STAT;
                            end else begin
                                r_state <= S_RD;
                            end
                        end else if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                end
                S_STAT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= '0;
                        r_out_user  <= r_status;
                        r_out_last  <= 1'b1;
                        r_state     <= S_LOAD;
                    end
                end
                S_RD: begin
                    r_ld_slot <= r_rk[1:0];
                    if (r_rk[2]) begin
                        r_gj    <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_rk <= r_rk + 3'd1;
                    end
                end
                S_SQ: begin
                    if (r_knot == crsc_pkg::KNOT_UNIFORM) begin
                        r_gap[0] <= crsc_pkg::GAP_UNIT;
                        r_gap[1] <= crsc_pkg::GAP_UNIT;
                        r_gap[2] <= crsc_pkg::GAP_UNIT;
                        r_state  <= S_TERM;
                    end else begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_state <= S_RT1;
                end
                S_RT1: begin
                    if (sq_done) begin
                        if (r_knot == crsc_pkg::KNOT_CHORDAL) begin
                            r_gap[r_gj] <= {sq_root, 1'b0};
                            if (r_gj == 2'd2) begin
                                r_state <= S_TERM;
                            end else begin
                                r_gj    <= r_gj + 2'd1;
                                r_state <= S_SQ;
                            end
                        end else begin
                            r_state <= S_RT2;
                        end
                    end
                end
                S_RT2: begin
                    if (sq_done) begin
                        r_gap[r_gj] <= {1'b0, sq_root};
                        if (r_gj == 2'd2) begin
                            r_state <= S_TERM;
                        end else begin
                            r_gj    <= r_gj + 2'd1;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_TERM: begin
                    r_state <= S_TWAIT;
                end
                S_TWAIT: begin
                    if (&lane_done) begin
                        r_ax    <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {2'd0, sel_coef.d, sel_coef.c, sel_coef.b,
                                        sel_coef.a, r_ax, r_span};
                        r_out_user  <= crsc_pkg::STAT_OK;
                        r_out_last  <= last_res;
                        if (r_ax == last_ax) begin
                            if (last_res) begin
                                r_state <= S_LOAD;
                            end else begin
                                r_span  <= r_span + 4'd1;
                                r_rk    <= '0;
                                r_state <= S_RD;
                            end
                        end else begin
                            r_ax <= r_ax + 2'd1;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_emit_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ({1'b0, r_span} < r_spans))
        else $error("emitting a span beyond the span count");

    a_stat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STAT) |-> (r_status != crsc_pkg::STAT_OK))
        else $error("status result without an error code");

    a_stat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != crsc_pkg::STAT_OK)) |-> o_m_axis_tlast)
        else $error("status result not marked last");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams control point curves into catmull_rom_span_coeffs under every knot
// mode, open and closed loops and two or three axes, and checks each span
// coefficient transfer against an in-bench curve coefficient predictor.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_PTS     = 16;
    localparam int ITEM_TARGET = 330;
    localparam int QUIET_AFTER = 290;
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [63:0] TERM_CAP = 64'd1 << 56;

    typedef struct {
        logic [3:0]  span;
        logic [1:0]  axis;
        logic [47:0] a;
        logic [47:0] b;
        logic [47:0] c;
        logic [47:0] d;
        logic [1:0]  status;
        logic        last;
    } t_coef_rec;

    class curve_scoreboard;
        logic [1:0]  knot_mode = 2'd2;
        logic        closed    = 1'b0;
        logic [1:0]  axes_cfg  = 2'd3;
        logic [31:0] sx[MAX_PTS];
        logic [31:0] sy[MAX_PTS];
        logic [31:0] sz[MAX_PTS];
        int          count     = 0;
        bit          ovf       = 0;
        t_coef_rec   q[$];
        int          errors    = 0;

        function void set_cfg(logic [1:0] idx, logic [1:0] v);
            if (idx == crsc_pkg::CFG_KNOT_MODE) knot_mode = v;
            else if (idx == crsc_pkg::CFG_CLOSED_LOOP) closed = v[0];
            else if (idx == crsc_pkg::CFG_AXIS_COUNT) axes_cfg = v;
        endfunction

        function logic signed [63:0] coord(int ax, int i);
            logic [31:0] v;
            v = (ax == 0) ? sx[i] : (ax == 1) ? sy[i] : sz[i];
            return {{32{v[31]}}, v};
        endfunction

        function logic [63:0] isqrt(logic [63:0] x);
            logic [63:0] res;
            logic [63:0] bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x   = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function logic [63:0] knot_gap(int ia, int ib, int axes);
            logic [63:0] sq;
            logic [63:0] m;
            logic [63:0] root_d;
            logic signed [63:0] dd;
            sq = 0;
            if (knot_mode == crsc_pkg::KNOT_UNIFORM) return 64'd65536;
            for (int ax = 0; ax < axes; ax++) begin
                dd = coord(ax, ib) - coord(ax, ia);
                if (dd < 0) m = -dd;
                else m = dd;
                sq = sq + ((m * m) >> 2);
            end
            root_d = isqrt(sq);
            if (knot_mode == crsc_pkg::KNOT_CHORDAL) return root_d << 1;
            return isqrt(root_d << 17);
        endfunction

        // v * n / d truncated toward zero, magnitude capped
        function logic signed [63:0] term(logic signed [63:0] v, logic [63:0] n,
                                          logic [63:0] d);
            logic [63:0]  mag;
            logic [127:0] prod;
            logic [127:0] quo;
            logic signed [63:0] r;
            if (v < 0) mag = -v;
            else mag = v;
            prod = {64'd0, mag} * {64'd0, n};
            quo  = prod / {64'd0, d};
            if (quo > {64'd0, TERM_CAP}) quo = {64'd0, TERM_CAP};
            r = quo[63:0];
            return (v < 0) ? -r : r;
        endfunction

        function logic [47:0] clamp48(logic signed [63:0] v);
            if (v > crsc_pkg::SAT_HI) v = crsc_pkg::SAT_HI;
            else if (v < crsc_pkg::SAT_LO) v = crsc_pkg::SAT_LO;
            return v[47:0];
        endfunction

        function void push(int span, int axis, logic signed [63:0] a,
                           logic signed [63:0] b, logic signed [63:0] c,
                           logic signed [63:0] d, logic [1:0] st, logic lst);
            t_coef_rec r;
            r.span   = span[3:0];
            r.axis   = axis[1:0];
            r.a      = clamp48(a);
            r.b      = clamp48(b);
            r.c      = clamp48(c);
            r.d      = clamp48(d);
            r.status = st;
            r.last   = lst;
            q.push_back(r);
        endfunction

        function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 logic fin);
            int n;
            int spans;
            int axes;
            int i0, i1, i2, i3;
            logic [63:0] g01, g12, g23;
            logic signed [63:0] p0, p1, p2, p3, m1, m2;
            if (count < MAX_PTS) begin
                sx[count] = x;
                sy[count] = y;
                sz[count] = z;
                count++;
            end else begin
                ovf = 1;
            end
            if (!fin) return;
            n     = count;
            count = 0;
            if (ovf) begin
                ovf = 0;
                push(0, 0, 0, 0, 0, 0, crsc_pkg::STAT_OVF, 1'b1);
                return;
            end
            if ((closed && n < 3) || (!closed && n < 4)) begin
                push(0, 0, 0, 0, 0, 0, crsc_pkg::STAT_FEW, 1'b1);
                return;
            end
            spans = closed ? n : n - 3;
            if (spans > crsc_pkg::SPAN_LIMIT) spans = crsc_pkg::SPAN_LIMIT;
            axes = (axes_cfg == 2'd2) ? 2 : 3;
            for (int s = 0; s < spans; s++) begin
                if (closed) begin
                    i0 = (s == 0) ? n - 1 : s - 1;
                    i1 = s;
                    i2 = (s + 1) % n;
                    i3 = (s + 2) % n;
                end else begin
                    i0 = s;
                    i1 = s + 1;
                    i2 = s + 2;
                    i3 = s + 3;
                end
                g01 = knot_gap(i0, i1, axes);
                g12 = knot_gap(i1, i2, axes);
                g23 = knot_gap(i2, i3, axes);
                for (int ax = 0; ax < axes; ax++) begin
                    p0 = coord(ax, i0);
                    p1 = coord(ax, i1);
                    p2 = coord(ax, i2);
                    p3 = coord(ax, i3);
                    m1 = 0;
                    m2 = 0;
                    // a zero knot gap flattens that tangent
                    if (g01 != 0 && g12 != 0)
                        m1 = (p2 - p1) - term(p2 - p0, g12, g01 + g12)
                             + term(p1 - p0, g12, g01);
                    if (g12 != 0 && g23 != 0)
                        m2 = (p2 - p1) - term(p3 - p1, g12, g12 + g23)
                             + term(p3 - p2, g12, g23);
                    push(s, ax, 2 * (p1 - p2) + m1 + m2,
                         3 * (p2 - p1) - 2 * m1 - m2, m1, p1, crsc_pkg::STAT_OK,
                         (s + 1 == spans && ax + 1 == axes));
                end
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %s: got %h want %h", what, got, want);
        endtask

        task check(t_coef_rec r);
            t_coef_rec e;
            if (q.size() == 0) begin
                report("unexpected transfer", {60'd0, r.span}, 64'd0);
                return;
            end
            e = q.pop_front();
            if (r.span != e.span) report("span_index", r.span, e.span);
            if (r.axis != e.axis) report("axis", r.axis, e.axis);
            if (r.a != e.a) report("coef_a", r.a, e.a);
            if (r.b != e.b) report("coef_b", r.b, e.b);
            if (r.c != e.c) report("coef_c", r.c, e.c);
            if (r.d != e.d) report("coef_d", r.d, e.d);
            if (r.status != e.status) report("status", r.status, e.status);
            if (r.last != e.last) report("last", r.last, e.last);
        endtask
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [95:0]  s_data = '0;
    logic         s_last = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [199:0] m_data;
    logic [1:0]   m_user;
    logic         m_last;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [1:0]   cfg_data = '0;

    curve_scoreboard sb = new();
    int  points_sent = 0;
    int  results_seen = 0;
    int  idle_cycles = 0;
    bit  quiet = 0;
    bit  held = 0;
    logic [31:0] px = 0, py = 0, pz = 0;

    catmull_rom_span_coeffs i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tlast (s_last),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tuser (m_user),
        .o_m_axis_tlast (m_last),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic fin);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_data  <= {z, y, x};
        s_last  <= fin;
        s_valid <= 1'b1;
        do @(posedge i_clk); while (!s_ready);
        sb.note_point(x, y, z, fin);
        points_sent++;
        if (points_sent >= QUIET_AFTER) quiet = 1;
    endtask

    function automatic logic [31:0] pick(logic [31:0] prev);
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return prev + $urandom_range(0, 131072) - 32'd65536;
            3: return prev;
            4: begin
                case ($urandom_range(0, 2))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    default: return 32'h0;
                endcase
            end
            default: return ($urandom & 32'h000f_ffff) ^ {32{$urandom_range(0, 1) == 1}};
        endcase
    endfunction

    task automatic send_curve(int n);
        for (int i = 0; i < n; i++) begin
            px = pick(px);
            py = pick(py);
            pz = pick(pz);
            send_point(px, py, pz, i == n - 1);
        end
    endtask

    // hold the sender until the block has drained, then let it settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (sb.q.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_config(logic [1:0] knot, logic [1:0] loop_cl, logic [1:0] axes);
        cfg_we    <= 1'b1;
        cfg_index <= crsc_pkg::CFG_KNOT_MODE;
        cfg_data  <= knot;
        @(posedge i_clk);
        sb.set_cfg(crsc_pkg::CFG_KNOT_MODE, knot);
        cfg_index <= crsc_pkg::CFG_CLOSED_LOOP;
        cfg_data  <= loop_cl;
        @(posedge i_clk);
        sb.set_cfg(crsc_pkg::CFG_CLOSED_LOOP, loop_cl);
        cfg_index <= crsc_pkg::CFG_AXIS_COUNT;
        cfg_data  <= axes;
        @(posedge i_clk);
        sb.set_cfg(crsc_pkg::CFG_AXIS_COUNT, axes);
        cfg_we <= 1'b0;
    endtask

    // result side: random stalls and one long hold-off
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (!quiet && !held && results_seen >= 60) begin
                held = 1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_coef_rec r;
        if (i_rst_n && m_valid && m_ready) begin
            r.span   = m_data[3:0];
            r.axis   = m_data[5:4];
            r.a      = m_data[53:6];
            r.b      = m_data[101:54];
            r.c      = m_data[149:102];
            r.d      = m_data[197:150];
            r.status = m_user;
            r.last   = m_last;
            sb.check(r);
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes of every coordinate, centripetal, open
        set_config(2'd2, 2'd0, 2'd3);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 1'b0);
        send_point(32'h0000_0000, 32'h0000_0000, 32'h7fff_ffff, 1'b1);
        // repeated point gives a zero knot gap, chordal closed two axes
        wait_idle();
        set_config(2'd1, 2'd1, 2'd2);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
        send_point(32'hfffe_0000, 32'h0005_0000, 32'hffff_ffff, 1'b1);
        // uniform open, then too few points
        wait_idle();
        set_config(2'd0, 2'd0, 2'd3);
        send_curve(4);
        send_curve(3);
        // unused modes, closed curves that are too short
        wait_idle();
        set_config(2'd3, 2'd1, 2'd0);
        send_curve(2);
        send_curve(1);

        while (points_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0) begin
                wait_idle();
                set_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 1)),
                           2'($urandom_range(0, 3)));
            end
            r = $urandom_range(0, 19);
            if (r < 15) send_curve($urandom_range(3, 8));
            else if (r < 18) send_curve($urandom_range(9, 16));
            else send_curve($urandom_range(17, 18));
        end
        s_valid <= 1'b0;

        do @(posedge i_clk); while (sb.q.size() != 0);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/core/crsc_pkg.sv
rtl/core/crsc_ram.sv
rtl/core/crsc_sqrt.sv
rtl/core/crsc_muldiv.sv
rtl/core/crsc_lane.sv
rtl/core/catmull_rom_span_coeffs.sv
dv/testbench.sv
